// ===== rtl/core/p2f_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2f_pkg
// Shared types and constants for the packet-to-flit transmitter.
// ----------------------------------------------------------------------------
package p2f_pkg;

    localparam int NODE_W   = 6;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 7;
    localparam int SEQ_W    = 6;
    localparam int KIND_W   = 2;
    localparam int MAX_FLITS = 64;

    // configuration register indexes
    localparam logic REG_NODE_ID = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEAD = 2'd0,
        KIND_BODY = 2'd1,
        KIND_TAIL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [TIME_W-1:0] pkt_time;
        logic [LEN_W-1:0]  length;
    } t_entry;

    // head of queue as seen by the sender, push already applied
    typedef struct packed {
        logic   avail;
        t_entry entry;
    } t_head;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] source;
        logic [NODE_W-1:0] dest;
        logic [TIME_W-1:0] pkt_time;
        logic [SEQ_W-1:0]  seq;
        t_kind             kind;
    } t_flit;

endpackage

// ===== rtl/core/p2f_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2f_queue
// Bounded packet FIFO with same-beat bypass of a push into an empty queue.
// ----------------------------------------------------------------------------
module p2f_queue import p2f_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  logic   i_inject,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_head  o_head,
    output logic   o_dropped
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_entry           r_mem [QUEUE_DEPTH];
    t_entry           r_head_entry;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic   push;
    t_entry wr_entry;

    always_comb begin
        wr_entry = i_entry;
        if (i_entry.length == '0) begin
            wr_entry.length = LEN_W'(1);
        end else if (i_entry.length > LEN_W'(MAX_FLITS)) begin
            wr_entry.length = LEN_W'(MAX_FLITS);
        end
    end

    assign push      = i_inject && (r_cnt < FULL_CNT);
    assign o_dropped = i_inject && (r_cnt >= FULL_CNT);

    // empty queue: the packet pushed this beat is the head
    always_comb begin
        o_head.avail = (r_cnt != '0) || push;
        o_head.entry = (r_cnt == '0) ? wr_entry : r_head_entry;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_step) begin
            if (push) begin
                n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            n_cnt = r_cnt + CNT_W'(push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && push) begin
            r_mem[r_wp] <= wr_entry;
        end
    end

    // head entry for the next beat; a push landing on the new read slot bypasses the array
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (push && (n_rp == r_wp)) begin
                r_head_entry <= wr_entry;
            end else begin
                r_head_entry <= r_mem[n_rp];
            end
        end
    end

endmodule

// ===== rtl/core/p2f_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2f_sender
// Flit segmentation and alternating-bit request level.
// ----------------------------------------------------------------------------
module p2f_sender import p2f_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_ack_level,
    input  logic [NODE_W-1:0] i_node_id,
    input  t_head             i_head,
    output logic              o_pop,
    output logic              o_level,
    output t_flit             o_flit
);

    logic [LEN_W-1:0] r_fr, n_fr;
    logic             r_tx, n_tx;

    logic             send;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] fr_eff;
    logic [LEN_W-1:0] fr_dec;

    assign send   = (i_ack_level == r_tx) && i_head.avail;
    assign len    = (i_head.entry.length == '0) ? LEN_W'(1) : i_head.entry.length;
    // zero count means the head packet has not started
    assign fr_eff = ((r_fr == '0) || (r_fr > len)) ? len : r_fr;
    assign fr_dec = fr_eff - LEN_W'(1);

    assign o_pop = send && (fr_dec == '0);

    always_comb begin
        o_flit = '0;
        if (send) begin
            o_flit.valid    = 1'b1;
            o_flit.source   = i_node_id;
            o_flit.dest     = i_head.entry.dest;
            o_flit.pkt_time = i_head.entry.pkt_time;
            o_flit.seq      = SEQ_W'(len - fr_eff);
            if (fr_eff == len) begin
                o_flit.kind = KIND_HEAD;
            end else if (fr_eff == LEN_W'(1)) begin
                o_flit.kind = KIND_TAIL;
            end else begin
                o_flit.kind = KIND_BODY;
            end
        end
    end

    always_comb begin
        n_fr = r_fr;
        n_tx = r_tx;
        if (i_step && send) begin
            n_fr = fr_dec;
            n_tx = ~r_tx;
        end
    end

    assign o_level = send ? ~r_tx : r_tx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr <= '0;
            r_tx <= 1'b0;
        end else begin
            r_fr <= n_fr;
            r_tx <= n_tx;
        end
    end

endmodule

// ===== rtl/core/packet_to_flit_transmitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_to_flit_transmitter_unit
// Transmit side of a NoC node interface: queues packets, sends at most one flit per
// tick under an alternating-bit request/acknowledge scheme.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  ------    -------------------------  -------------------------------------
//  input     i_in_valid / o_in_stall    inject, dest, time, length, ack level
//  output    o_out_valid / i_out_stall  flit fields, request level, dropped
//  config    APB psel/penable/pwrite    node_id at byte address 0
//
//  One beat per cycle sustained while the output is not stalled; each beat
//  goes through the input register, then queue/segmentation logic into the
//  result register.
//  Synchronous active-low reset clears pointers, counts, level and valids.
//  Output stall holds the result register and backs up through the input
//  register, so no beat is lost while stalled.
// ----------------------------------------------------------------------------
module packet_to_flit_transmitter_unit import p2f_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_inject,
    input  logic [NODE_W-1:0] i_dest_node,
    input  logic [TIME_W-1:0] i_packet_time,
    input  logic [LEN_W-1:0]  i_packet_length,
    input  logic              i_ack_level,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_flit_valid,
    output logic [NODE_W-1:0] o_flit_source,
    output logic [NODE_W-1:0] o_flit_dest,
    output logic [TIME_W-1:0] o_flit_time,
    output logic [SEQ_W-1:0]  o_flit_seq,
    output logic [KIND_W-1:0] o_flit_kind,
    output logic              o_request_level,
    output logic              o_dropped
);

    logic [NODE_W-1:0] r_node_id;

    logic   r_in_valid;
    logic   r_inject;
    logic   r_ack;
    t_entry r_in_entry;

    logic  r_out_valid;
    t_flit r_flit;
    logic  r_level;
    logic  r_dropped;

    logic  step;
    logic  in_take;
    t_head head;
    logic  pop;
    logic  level;
    logic  dropped;
    t_flit flit;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_ID) ? {{(32-NODE_W){1'b0}}, r_node_id} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_NODE_ID) begin
            r_node_id <= pwdata[NODE_W-1:0];
        end
    end

    // beat moves from input register into result register
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_inject            <= i_inject;
            r_ack               <= i_ack_level;
            r_in_entry.dest     <= i_dest_node;
            r_in_entry.pkt_time <= i_packet_time;
            r_in_entry.length   <= i_packet_length;
        end
    end

    p2f_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_inject  (r_inject),
        .i_entry   (r_in_entry),
        .i_pop     (pop),
        .o_head    (head),
        .o_dropped (dropped)
    );

    p2f_sender u_sender (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ack_level (r_ack),
        .i_node_id   (r_node_id),
        .i_head      (head),
        .o_pop       (pop),
        .o_level     (level),
        .o_flit      (flit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_flit    <= flit;
            r_level   <= level;
            r_dropped <= dropped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_flit_valid    = r_flit.valid;
    assign o_flit_source   = r_flit.source;
    assign o_flit_dest     = r_flit.dest;
    assign o_flit_time     = r_flit.pkt_time;
    assign o_flit_seq      = r_flit.seq;
    assign o_flit_kind     = r_flit.kind;
    assign o_request_level = r_level;
    assign o_dropped       = r_dropped;

endmodule

// ===== test/flit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flit_checker
// Watches the config port and both channels of the packet-to-flit
// transmitter, keeps its own copy of the packet queue and segmentation
// state, predicts one result per accepted input beat and compares every
// accepted output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module flit_checker import p2f_pkg::*; #(
    parameter int QDEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [2:0]        i_paddr,
    input  logic [31:0]       i_pwdata,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_inject,
    input  logic [NODE_W-1:0] i_dest_node,
    input  logic [TIME_W-1:0] i_packet_time,
    input  logic [LEN_W-1:0]  i_packet_length,
    input  logic              i_ack_level,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_flit_valid,
    input  logic [NODE_W-1:0] i_flit_source,
    input  logic [NODE_W-1:0] i_flit_dest,
    input  logic [TIME_W-1:0] i_flit_time,
    input  logic [SEQ_W-1:0]  i_flit_seq,
    input  logic [KIND_W-1:0] i_flit_kind,
    input  logic              i_request_level,
    input  logic              i_dropped,

    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        t_flit flit;
        logic  level;
        logic  dropped;
    } t_tick;

    t_entry            pkt_store [QDEPTH];
    int unsigned       rd_idx;
    int unsigned       wr_idx;
    int unsigned       pkt_count;
    logic [LEN_W-1:0]  flits_left;
    logic              tx_level;
    logic [NODE_W-1:0] node_id;
    t_tick             tick_q [$];
    int                beat_no;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 40) begin
            $display("ERROR at %0t, output beat %0d: %s", $realtime, beat_no, msg);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, should be %0h", what, got, want));
        end
    endtask

    // one tick: queue the offer first, then maybe send one flit of the head packet
    function automatic t_tick segment_tick(input logic inject, input logic [NODE_W-1:0] dest,
                                           input logic [TIME_W-1:0] stamp,
                                           input logic [LEN_W-1:0] len, input logic ack);
        t_tick            r;
        t_entry           head;
        logic [LEN_W-1:0] plen;
        r = '0;
        if (inject) begin
            if (pkt_count >= QDEPTH) begin
                r.dropped = 1'b1;
            end else begin
                plen = len;
                if (plen == 0) plen = LEN_W'(1);
                if (plen > MAX_FLITS) plen = LEN_W'(MAX_FLITS);
                pkt_store[wr_idx] = '{dest: dest, pkt_time: stamp, length: plen};
                wr_idx = (wr_idx + 1) % QDEPTH;
                pkt_count++;
            end
        end
        if (ack == tx_level && pkt_count != 0) begin
            head = pkt_store[rd_idx];
            if (flits_left == 0 || flits_left > head.length) flits_left = head.length;
            r.flit.valid    = 1'b1;
            r.flit.source   = node_id;
            r.flit.dest     = head.dest;
            r.flit.pkt_time = head.pkt_time;
            r.flit.seq      = SEQ_W'(head.length - flits_left);
            // head wins over tail for one-flit packets
            if (flits_left == head.length)
                r.flit.kind = KIND_HEAD;
            else if (flits_left == 1)
                r.flit.kind = KIND_TAIL;
            else
                r.flit.kind = KIND_BODY;
            flits_left--;
            if (flits_left == 0) begin
                rd_idx = (rd_idx + 1) % QDEPTH;
                pkt_count--;
            end
            tx_level = ~tx_level;
        end
        r.level = tx_level;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tick want;
        if (!i_rst_n) begin
            foreach (pkt_store[k]) pkt_store[k] = '0;
            rd_idx     = 0;
            wr_idx     = 0;
            pkt_count  = 0;
            flits_left = '0;
            tx_level   = 1'b0;
            node_id    = '0;
            beat_no    = 0;
            tick_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == 3'(4 * REG_NODE_ID)) begin
                node_id = i_pwdata[NODE_W-1:0];
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                tick_q.push_back(segment_tick(i_inject, i_dest_node, i_packet_time,
                                              i_packet_length, i_ack_level));
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (tick_q.size() == 0) begin
                    report_mismatch("output beat with nothing outstanding");
                end else begin
                    want = tick_q.pop_front();
                    check_field("flit_valid", 32'(i_flit_valid), 32'(want.flit.valid));
                    check_field("flit_source", 32'(i_flit_source), 32'(want.flit.source));
                    check_field("flit_dest", 32'(i_flit_dest), 32'(want.flit.dest));
                    check_field("flit_time", i_flit_time, want.flit.pkt_time);
                    check_field("flit_seq", 32'(i_flit_seq), 32'(want.flit.seq));
                    check_field("flit_kind", 32'(i_flit_kind), 32'(want.flit.kind));
                    check_field("request_level", 32'(i_request_level), 32'(want.level));
                    check_field("dropped", 32'(i_dropped), 32'(want.dropped));
                end
                beat_no++;
            end
        end
        o_pending = tick_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the packet-to-flit transmitter: a directed sweep of the queue
// corner cases, then random ticks in several node-id settings with random
// idling on both sides, two long output hold-offs and drain pauses. Checking is
// done by flit_checker; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb import p2f_pkg::*;;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_ITEMS = 140;

    typedef enum int {ACK_FOLLOW, ACK_FLIP, ACK_RANDOM} t_ack_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_inject = 1'b0;
    logic [NODE_W-1:0] i_dest_node = '0;
    logic [TIME_W-1:0] i_packet_time = '0;
    logic [LEN_W-1:0]  i_packet_length = '0;
    logic              i_ack_level = 1'b0;

    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_flit_valid;
    logic [NODE_W-1:0] o_flit_source;
    logic [NODE_W-1:0] o_flit_dest;
    logic [TIME_W-1:0] o_flit_time;
    logic [SEQ_W-1:0]  o_flit_seq;
    logic [KIND_W-1:0] o_flit_kind;
    logic              o_request_level;
    logic              o_dropped;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   beats_taken = 0;
    bit   calm = 1'b1;
    logic seen_level = 1'b0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    packet_to_flit_transmitter_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_inject        (i_inject),
        .i_dest_node     (i_dest_node),
        .i_packet_time   (i_packet_time),
        .i_packet_length (i_packet_length),
        .i_ack_level     (i_ack_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_flit_valid    (o_flit_valid),
        .o_flit_source   (o_flit_source),
        .o_flit_dest     (o_flit_dest),
        .o_flit_time     (o_flit_time),
        .o_flit_seq      (o_flit_seq),
        .o_flit_kind     (o_flit_kind),
        .o_request_level (o_request_level),
        .o_dropped       (o_dropped)
    );

    flit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_inject        (i_inject),
        .i_dest_node     (i_dest_node),
        .i_packet_time   (i_packet_time),
        .i_packet_length (i_packet_length),
        .i_ack_level     (i_ack_level),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_flit_valid    (o_flit_valid),
        .i_flit_source   (o_flit_source),
        .i_flit_dest     (o_flit_dest),
        .i_flit_time     (o_flit_time),
        .i_flit_seq      (o_flit_seq),
        .i_flit_kind     (o_flit_kind),
        .i_request_level (o_request_level),
        .i_dropped       (o_dropped),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid and hold off until every outstanding beat is back;
    // the count is sampled mid-cycle, once the checker has settled
    task automatic wait_drained(input int extra);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // ack follows the last request level seen at the output, or deliberately not
    task automatic offer_tick(input logic inject, input logic [NODE_W-1:0] dest,
                              input logic [TIME_W-1:0] stamp, input logic [LEN_W-1:0] len,
                              input t_ack_mode mode);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_inject        <= inject;
        i_dest_node     <= dest;
        i_packet_time   <= stamp;
        i_packet_length <= len;
        case (mode)
            ACK_FOLLOW: i_ack_level <= seen_level;
            ACK_FLIP:   i_ack_level <= ~seen_level;
            default:    i_ack_level <= 1'($urandom_range(0, 1));
        endcase
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic random_tick(input int inject_pct);
        int               r;
        logic [LEN_W-1:0] len;
        t_ack_mode        mode;
        r = $urandom_range(0, 99);
        // mostly short packets so the queue turns over; a few long and out-of-range
        if (r < 55)      len = LEN_W'($urandom_range(1, 3));
        else if (r < 85) len = LEN_W'($urandom_range(4, 12));
        else if (r < 92) len = LEN_W'($urandom_range(13, 63));
        else if (r < 97) len = LEN_W'($urandom_range(64, 127));
        else             len = '0;
        r = $urandom_range(0, 99);
        if (r < 75)      mode = ACK_FOLLOW;
        else if (r < 87) mode = ACK_FLIP;
        else             mode = ACK_RANDOM;
        offer_tick($urandom_range(0, 99) < inject_pct, NODE_W'($urandom), $urandom, len,
                   mode);
    endtask

    // output side: random stall per beat, two long hold-offs mid-run
    initial begin
        int gap;
        forever begin
            gap = calm ? 0 : $urandom_range(0, 14);
            if (beats_taken == 90 || beats_taken == 370) gap = 80;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            seen_level = o_request_level;
            beats_taken++;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int               fill_len [8];
        int               inject_pct [5];
        logic [NODE_W-1:0] phase_node [5];
        logic [NODE_W-1:0] node;
        fill_len   = '{2, 3, 1, 2, 4, 1, 6, 2};
        inject_pct = '{25, 10, 50, 35, 20};
        phase_node = '{6'd0, 6'h2A, 6'd0, 6'h3F, 6'd0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: one tick at a time with the pipe empty, so the level is known
        write_reg(3'(4 * REG_NODE_ID), 32'h3F);
        calm = 1'b1;
        wait_drained(2);
        offer_tick(1'b0, 6'h00, 32'h0, 7'd1, ACK_FOLLOW);            // empty queue
        wait_drained(2);
        offer_tick(1'b1, 6'h3F, 32'hFFFF_FFFF, 7'd1, ACK_FOLLOW);    // push and head, same tick
        wait_drained(2);
        offer_tick(1'b1, 6'h00, 32'h0, 7'd0, ACK_FOLLOW);            // zero length
        for (int k = 0; k < 8; k++) begin
            wait_drained(2);
            offer_tick(1'b1, NODE_W'(k * 9), 32'hA5A5_A5A5 ^ k, LEN_W'(fill_len[k]), ACK_FLIP);
        end
        wait_drained(2);
        offer_tick(1'b1, 6'h15, 32'h1234_5678, 7'd5, ACK_FLIP);      // full: dropped
        wait_drained(2);
        offer_tick(1'b0, 6'h00, 32'h0, 7'd1, ACK_FOLLOW);            // head of 2-flit packet
        wait_drained(2);
        offer_tick(1'b1, 6'h2A, 32'h0F0F_0F0F, 7'd1, ACK_FOLLOW);    // tail pops, offer dropped
        wait_drained(2);
        offer_tick(1'b1, 6'h2A, 32'h5A5A_5A5A, 7'd127, ACK_FLIP);    // saturates to max
        repeat (3) begin
            wait_drained(2);
            offer_tick(1'b0, 6'h00, 32'h0, 7'd1, ACK_FOLLOW);        // head, body, tail
        end
        wait_drained(2);
        offer_tick(1'b1, 6'h01, 32'h8000_0001, 7'd64, ACK_FOLLOW);
        wait_drained(2);
        offer_tick(1'b1, 6'h20, 32'h7FFF_FFFE, 7'd65, ACK_RANDOM);
        wait_drained(4);

        for (int p = 0; p < 5; p++) begin
            node = (p == 2 || p == 4) ? NODE_W'($urandom) : phase_node[p];
            write_reg(3'(4 * REG_NODE_ID), {26'd0, node});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 35 == 0) calm = ($urandom_range(0, 3) == 0);
                random_tick(inject_pct[p]);
            end
            wait_drained(4);
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
